FILE: sv/nncm_pkg.sv
// ----------------------------------------------------------------------------
// nncm_pkg
// Shared types and constants of the nearest-neighbor coordinate mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package nncm_pkg;

   localparam int CW         = 13;   // coordinate, dimension and quotient width
   localparam int AXES       = 2;    // lane 0 is horizontal, lane 1 vertical
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 4;
   localparam int NUM_CELLS  = CW;   // one quotient bit per cell

   typedef logic [CW-1:0] coord_type;
   typedef coord_type [AXES-1:0] lane_vec_type;

   localparam coord_type COORD_MAX = '1;
   localparam logic      FUNC_INV  = 1'b1;

   typedef enum logic [1:0] {
      REG_SRC_W = 2'd0,
      REG_SRC_H = 2'd1,
      REG_DST_W = 2'd2,
      REG_DST_H = 2'd3
   } reg_index_type;

   // carried through the shift divider
   typedef struct packed {
      logic         func;
      lane_vec_type coord;
   } a_side_type;

   // carried through the main divider
   typedef struct packed {
      logic            func;
      lane_vec_type    shift;
      logic [AXES-1:0] zero;
      logic [AXES-1:0] ovf;
   } b_side_type;

   localparam int A_SIDE_W = $bits(a_side_type);
   localparam int B_SIDE_W = $bits(b_side_type);

endpackage

`default_nettype wire

FILE: sv/nncm_req_if.sv
// ----------------------------------------------------------------------------
// nncm_req_if
// Request channel: mode and coordinate pair to map.
// ----------------------------------------------------------------------------
`default_nettype none

interface nncm_req_if;
   import nncm_pkg::*;

   logic      valid;
   logic      ready;
   logic      func;
   coord_type coord_x;
   coord_type coord_y;

   modport source (output valid, func, coord_x, coord_y, input ready);
   modport sink   (input valid, func, coord_x, coord_y, output ready);
endinterface

`default_nettype wire

FILE: sv/nncm_rsp_if.sv
// ----------------------------------------------------------------------------
// nncm_rsp_if
// Response channel: mapped coordinate pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface nncm_rsp_if;
   import nncm_pkg::*;

   logic      valid;
   logic      ready;
   coord_type mapped_x;
   coord_type mapped_y;

   modport source (output valid, mapped_x, mapped_y, input ready);
   modport sink   (input valid, mapped_x, mapped_y, output ready);
endinterface

`default_nettype wire

FILE: sv/nncm_div_cell.sv
// ----------------------------------------------------------------------------
// nncm_div_cell
// One restoring-division step for both axes, registered, with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module nncm_div_cell #(
   parameter int SW = 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  up_valid,
   output logic                       up_ready,
   input  wire nncm_pkg::lane_vec_type divisor,
   input  wire nncm_pkg::lane_vec_type up_rem,
   input  wire nncm_pkg::lane_vec_type up_num,
   input  wire logic [SW-1:0]         up_side,
   output logic                       dn_valid,
   input  wire logic                  dn_ready,
   output nncm_pkg::lane_vec_type     dn_rem,
   output nncm_pkg::lane_vec_type     dn_num,
   output logic [SW-1:0]              dn_side
);
   import nncm_pkg::*;

   logic                  valid_ff, valid_in;
   lane_vec_type          rem_ff, rem_in;
   lane_vec_type          num_ff, num_in;
   logic [SW-1:0]         side_ff;
   logic [AXES-1:0][CW:0] trial, diff;
   logic [AXES-1:0]       fits;

   // num shifts out dividend bits at the top and takes quotient bits at the bottom
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         trial[i]  = {up_rem[i], up_num[i][CW-1]};
         diff[i]   = trial[i] - {1'b0, divisor[i]};
         fits[i]   = trial[i] >= {1'b0, divisor[i]};
         rem_in[i] = fits[i] ? diff[i][CW-1:0] : trial[i][CW-1:0];
         num_in[i] = {up_num[i][CW-2:0], fits[i]};
      end
      up_ready = !valid_ff || dn_ready;
      valid_in = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_num   = num_ff;
   assign dn_side  = side_ff;

endmodule

`default_nettype wire

FILE: sv/nncm_prep.sv
// ----------------------------------------------------------------------------
// nncm_prep
// Centering shift, operand select, then multiply-add into the main dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module nncm_prep (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   up_valid,
   output logic                        up_ready,
   input  wire nncm_pkg::a_side_type   up_side,
   input  wire nncm_pkg::lane_vec_type up_quot,
   input  wire nncm_pkg::lane_vec_type src_dim,
   input  wire nncm_pkg::lane_vec_type dst_dim,
   output logic                        dn_valid,
   input  wire logic                   dn_ready,
   output nncm_pkg::lane_vec_type      dn_rem,
   output nncm_pkg::lane_vec_type      dn_num,
   output nncm_pkg::b_side_type        dn_side
);
   import nncm_pkg::*;

   // stage 1: operand select
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_func_ff;
   lane_vec_type    s1_mul_a_ff, s1_mul_a_in;
   lane_vec_type    s1_mul_b_ff, s1_mul_b_in;
   lane_vec_type    s1_add_ff, s1_add_in;
   lane_vec_type    s1_div_ff, s1_div_in;
   lane_vec_type    s1_shift_ff, s1_shift_in;
   logic [AXES-1:0] s1_zero_ff, s1_zero_in;
   logic            s1_ready;

   // stage 2: multiply-add
   logic                    s2_valid_ff, s2_valid_in;
   lane_vec_type            s2_rem_ff, s2_num_ff;
   b_side_type              s2_side_ff, s2_side_in;
   logic [AXES-1:0][2*CW-1:0] prod;
   logic                    s2_ready;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         s1_shift_in[i] = (up_quot[i] == '0) ? '0 : ((up_quot[i] - 1'b1) >> 1);
         if (up_side.func == FUNC_INV) begin
            s1_zero_in[i]  = up_side.coord[i] <= s1_shift_in[i];
            s1_mul_a_in[i] = up_side.coord[i] - s1_shift_in[i];
            s1_mul_b_in[i] = dst_dim[i];
            s1_add_in[i]   = src_dim[i] - 1'b1;
            s1_div_in[i]   = src_dim[i];
         end else begin
            s1_zero_in[i]  = 1'b0;
            s1_mul_a_in[i] = up_side.coord[i];
            s1_mul_b_in[i] = src_dim[i];
            s1_add_in[i]   = '0;
            s1_div_in[i]   = dst_dim[i];
         end
      end
      s2_ready    = !s2_valid_ff || dn_ready;
      s1_ready    = !s1_valid_ff || s2_ready;
      up_ready    = s1_ready;
      s1_valid_in = s1_ready ? up_valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   // product fits in 2*CW bits even with the rounding addend
   always_comb begin
      s2_side_in.func  = s1_func_ff;
      s2_side_in.shift = s1_shift_ff;
      s2_side_in.zero  = s1_zero_ff;
      for (int i = 0; i < AXES; i++) begin
         prod[i] = (2*CW)'(s1_mul_a_ff[i]) * (2*CW)'(s1_mul_b_ff[i])
                 + (2*CW)'(s1_add_ff[i]);
         s2_side_in.ovf[i] = prod[i][2*CW-1:CW] >= s1_div_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && up_valid) begin
         s1_func_ff  <= up_side.func;
         s1_mul_a_ff <= s1_mul_a_in;
         s1_mul_b_ff <= s1_mul_b_in;
         s1_add_ff   <= s1_add_in;
         s1_div_ff   <= s1_div_in;
         s1_shift_ff <= s1_shift_in;
         s1_zero_ff  <= s1_zero_in;
      end
      if (s2_ready && s1_valid_ff) begin
         for (int i = 0; i < AXES; i++) begin
            s2_rem_ff[i] <= prod[i][2*CW-1:CW];
            s2_num_ff[i] <= prod[i][CW-1:0];
         end
         s2_side_ff <= s2_side_in;
      end
   end

   assign dn_valid = s2_valid_ff;
   assign dn_rem   = s2_rem_ff;
   assign dn_num   = s2_num_ff;
   assign dn_side  = s2_side_ff;

endmodule

`default_nettype wire

FILE: sv/nearest_neighbor_coord_map_top.sv
// pipeline: request beat to response valid through 13 shift-divider
//   cells, 2 prep stages, 13 main-divider cells and 1 output register
// throughput: one beat per cycle while rsp.ready is high, set by the fully pipelined divider cells
// reset: clears all pipeline valids; the four dimension registers reset to 1
// ----------------------------------------------------------------------------
// nearest_neighbor_coord_map_top
// Nearest-neighbor scaler coordinate mapper with register port.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_coord_map_top #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   nncm_req_if.sink                          req,
   nncm_rsp_if.source                        rsp,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [nncm_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [nncm_pkg::DATA_W-1:0]  csr_pwdata,
   output logic      [nncm_pkg::DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import nncm_pkg::*;

   localparam coord_type DIM_CAP = (MAX_DIM > int'(COORD_MAX)) ? COORD_MAX
                                                                : coord_type'(MAX_DIM);

   // ---------------- registers ----------------
   coord_type     src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   reg_index_type csr_index;
   logic          csr_write;

   assign csr_index  = reg_index_type'(csr_paddr[ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= coord_type'(1);
         src_h_ff <= coord_type'(1);
         dst_w_ff <= coord_type'(1);
         dst_h_ff <= coord_type'(1);
      end else if (csr_write) begin
         case (csr_index)
            REG_SRC_W: src_w_ff <= csr_pwdata[CW-1:0];
            REG_SRC_H: src_h_ff <= csr_pwdata[CW-1:0];
            REG_DST_W: dst_w_ff <= csr_pwdata[CW-1:0];
            REG_DST_H: dst_h_ff <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_SRC_W: csr_prdata = DATA_W'(src_w_ff);
         REG_SRC_H: csr_prdata = DATA_W'(src_h_ff);
         REG_DST_W: csr_prdata = DATA_W'(dst_w_ff);
         REG_DST_H: csr_prdata = DATA_W'(dst_h_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // dimensions in use are clamped to 1..MAX_DIM, and never above COORD_MAX
   lane_vec_type src_raw, dst_raw, src_dim, dst_dim;

   always_comb begin
      src_raw[0] = src_w_ff;
      src_raw[1] = src_h_ff;
      dst_raw[0] = dst_w_ff;
      dst_raw[1] = dst_h_ff;
      for (int i = 0; i < AXES; i++) begin
         src_dim[i] = (src_raw[i] == '0) ? coord_type'(1)
                    : (src_raw[i] > DIM_CAP) ? DIM_CAP : src_raw[i];
         dst_dim[i] = (dst_raw[i] == '0) ? coord_type'(1)
                    : (dst_raw[i] > DIM_CAP) ? DIM_CAP : dst_raw[i];
      end
   end

   // ---------------- shift divider: src / dst ----------------
   logic                a_valid [NUM_CELLS+1];
   logic                a_ready [NUM_CELLS+1];
   lane_vec_type        a_rem   [NUM_CELLS+1];
   lane_vec_type        a_num   [NUM_CELLS+1];
   logic [A_SIDE_W-1:0] a_side  [NUM_CELLS+1];
   a_side_type          a_hdr;

   always_comb begin
      a_hdr.func     = req.func;
      a_hdr.coord[0] = req.coord_x;
      a_hdr.coord[1] = req.coord_y;
   end

   assign a_valid[0] = req.valid;
   assign req.ready  = a_ready[0];
   assign a_rem[0]   = '0;
   assign a_num[0]   = src_dim;
   assign a_side[0]  = a_hdr;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_shift_div
      nncm_div_cell #(
         .SW (A_SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (a_valid[k]),
         .up_ready (a_ready[k]),
         .divisor  (dst_dim),
         .up_rem   (a_rem[k]),
         .up_num   (a_num[k]),
         .up_side  (a_side[k]),
         .dn_valid (a_valid[k+1]),
         .dn_ready (a_ready[k+1]),
         .dn_rem   (a_rem[k+1]),
         .dn_num   (a_num[k+1]),
         .dn_side  (a_side[k+1])
      );
   end

   // ---------------- operand prep and multiply ----------------
   logic                b_valid [NUM_CELLS+1];
   logic                b_ready [NUM_CELLS+1];
   lane_vec_type        b_rem   [NUM_CELLS+1];
   lane_vec_type        b_num   [NUM_CELLS+1];
   logic [B_SIDE_W-1:0] b_side  [NUM_CELLS+1];
   lane_vec_type        b_div   [NUM_CELLS+1];
   b_side_type          prep_side;

   nncm_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (a_valid[NUM_CELLS]),
      .up_ready (a_ready[NUM_CELLS]),
      .up_side  (a_side_type'(a_side[NUM_CELLS])),
      .up_quot  (a_num[NUM_CELLS]),
      .src_dim  (src_dim),
      .dst_dim  (dst_dim),
      .dn_valid (b_valid[0]),
      .dn_ready (b_ready[0]),
      .dn_rem   (b_rem[0]),
      .dn_num   (b_num[0]),
      .dn_side  (prep_side)
   );

   assign b_side[0] = prep_side;

   // divisor follows the beat held at each cell's input
   for (genvar k = 0; k <= NUM_CELLS; k++) begin : g_main_sel
      b_side_type hdr;
      assign hdr      = b_side_type'(b_side[k]);
      assign b_div[k] = (hdr.func == FUNC_INV) ? src_dim : dst_dim;
   end

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_main_div
      nncm_div_cell #(
         .SW (B_SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (b_valid[k]),
         .up_ready (b_ready[k]),
         .divisor  (b_div[k]),
         .up_rem   (b_rem[k]),
         .up_num   (b_num[k]),
         .up_side  (b_side[k]),
         .dn_valid (b_valid[k+1]),
         .dn_ready (b_ready[k+1]),
         .dn_rem   (b_rem[k+1]),
         .dn_num   (b_num[k+1]),
         .dn_side  (b_side[k+1])
      );
   end

   // ---------------- output register ----------------
   b_side_type            fin_side;
   lane_vec_type          mapped_ff, mapped_in;
   logic [AXES-1:0][CW:0] fwd_sum;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign b_ready[NUM_CELLS] = !rsp_valid_ff || rsp.ready;

   always_comb begin
      fin_side = b_side_type'(b_side[NUM_CELLS]);
      for (int i = 0; i < AXES; i++) begin
         fwd_sum[i] = {1'b0, fin_side.shift[i]} + {1'b0, b_num[NUM_CELLS][i]};
         if (fin_side.func == FUNC_INV) begin
            mapped_in[i] = fin_side.zero[i] ? '0
                         : fin_side.ovf[i]  ? COORD_MAX : b_num[NUM_CELLS][i];
         end else begin
            mapped_in[i] = (fin_side.ovf[i] || fwd_sum[i][CW]) ? COORD_MAX
                                                                 : fwd_sum[i][CW-1:0];
         end
      end
      rsp_valid_in = b_ready[NUM_CELLS] ? b_valid[NUM_CELLS] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready[NUM_CELLS] && b_valid[NUM_CELLS]) begin
         mapped_ff <= mapped_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.mapped_x = mapped_ff[0];
   assign rsp.mapped_y = mapped_ff[1];

   // ---------------- checks ----------------
`ifndef NO_ASSERTIONS
   // remainder stays below the divisor through the shift divider
   a_shift_rem_bound: assert property (@(posedge clock) disable iff (reset)
      a_valid[NUM_CELLS] |->
         (a_rem[NUM_CELLS][0] < dst_dim[0]) && (a_rem[NUM_CELLS][1] < dst_dim[1]))
      else $error("shift divider remainder out of range");

   // without overflow the main divider remainder stays below its divisor
   a_main_rem_bound_x: assert property (@(posedge clock) disable iff (reset)
      b_valid[NUM_CELLS] && !fin_side.ovf[0] |->
         b_rem[NUM_CELLS][0] < b_div[NUM_CELLS][0])
      else $error("main divider remainder out of range on x");

   a_main_rem_bound_y: assert property (@(posedge clock) disable iff (reset)
      b_valid[NUM_CELLS] && !fin_side.ovf[1] |->
         b_rem[NUM_CELLS][1] < b_div[NUM_CELLS][1])
      else $error("main divider remainder out of range on y");
`endif

endmodule

`default_nettype wire
